// ----- hdl/b32e_pkg.sv -----
// Shared types, constants and the alphabet lookup for the Base32 stream encoder.
package b32e_pkg;

  localparam int SymW = 5;
  localparam int CharW = 7;
  localparam int SlotN = 3;
  localparam logic [CharW-1:0] PadChar = 7'h3D;
  localparam logic [CharW-1:0] UpperBase = 7'h41;
  localparam logic [CharW-1:0] DigitBase = 7'h32;
  localparam logic [SymW-1:0] DigitStart = 5'd26;

  // One request's work for the back end: up to three symbols, then padding.
  typedef struct packed {
    logic [SlotN-1:0][SymW-1:0] sym;
    logic [1:0]                 nsym;
    logic [2:0]                 npad;
    logic                       fin;
  } job_t;

  // Map a 5-bit symbol to its ASCII character (A-Z, then 2-7).
  function automatic logic [CharW-1:0] sym_to_char(input logic [SymW-1:0] v);
    logic [CharW-1:0] ch;
    if (v < DigitStart) begin
      ch = UpperBase + {2'b00, v};
    end else begin
      ch = DigitBase + {2'b00, v - DigitStart};
    end
    return ch;
  endfunction

endpackage

// ----- hdl/b32e_front.sv -----
// Front end: accepts bytes, slices them into 5-bit symbols and plans padding.
module b32e_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  logic [7:0]    data_byte,
  input  logic          is_final,
  output b32e_pkg::job_t job
);
  import b32e_pkg::*;

  logic [3:0]  lo_bits_r, lo_bits_nxt;
  logic [2:0]  lo_cnt_r, lo_cnt_nxt;
  logic [2:0]  mod_r, mod_nxt;

  logic [2:0]  cnt_c;
  logic [3:0]  held;
  logic [11:0] acc;
  logic [11:0] sh0, sh1;
  logic        two;
  logic [2:0]  nrem;
  logic [3:0]  rem_bits;
  logic [SymW:0] tail_w;
  logic [SymW-1:0] tail_sym;
  logic        has_tail;
  logic [1:0]  nsym;
  logic [2:0]  mod_sum;

  // Build the bit window from held-over bits and the new byte
  always_comb begin
    cnt_c    = (lo_cnt_r > 3'd4) ? 3'd4 : lo_cnt_r;
    held     = lo_bits_r & ((4'd1 << cnt_c) - 4'd1);
    acc      = {held, data_byte};
    two      = (cnt_c >= 3'd2);
    sh0      = acc >> ({1'b0, cnt_c} + 4'd3);
    sh1      = two ? (acc >> ({1'b0, cnt_c} - 4'd2)) : 12'd0;
    nrem     = two ? (cnt_c - 3'd2) : (cnt_c + 3'd3);
    rem_bits = acc[3:0] & ((4'd1 << nrem) - 4'd1);
    tail_w   = {2'b00, rem_bits} << (3'd5 - nrem);
    tail_sym = tail_w[SymW-1:0];
    has_tail = is_final && (nrem != 3'd0);
    nsym     = (two ? 2'd2 : 2'd1) + {1'b0, has_tail};
    mod_sum  = mod_r + {1'b0, nsym};
  end

  // Assemble the request for the back end
  always_comb begin
    job.sym[0] = sh0[SymW-1:0];
    job.sym[1] = two ? sh1[SymW-1:0] : tail_sym;
    job.sym[2] = tail_sym;
    job.nsym   = nsym;
    job.npad   = is_final ? (3'd0 - mod_sum) : 3'd0;
    job.fin    = is_final;
  end

  // Advance the stream state, clearing it after a final byte
  always_comb begin
    lo_bits_nxt = lo_bits_r;
    lo_cnt_nxt  = lo_cnt_r;
    mod_nxt     = mod_r;
    if (accept) begin
      if (is_final) begin
        lo_bits_nxt = 4'd0;
        lo_cnt_nxt  = 3'd0;
        mod_nxt     = 3'd0;
      end else begin
        lo_bits_nxt = rem_bits;
        lo_cnt_nxt  = nrem;
        mod_nxt     = mod_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_bits_r <= 4'd0;
      lo_cnt_r  <= 3'd0;
      mod_r     <= 3'd0;
    end else begin
      lo_bits_r <= lo_bits_nxt;
      lo_cnt_r  <= lo_cnt_nxt;
      mod_r     <= mod_nxt;
    end
  end

endmodule

// ----- hdl/b32e_queue.sv -----
// Two-entry request queue between the front end and the back end.
module b32e_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  b32e_pkg::job_t wr_job,
  output logic           full,
  input  logic           rd_en,
  output logic           rd_valid,
  output b32e_pkg::job_t rd_job
);
  import b32e_pkg::*;

  job_t       slot_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full     = (cnt_r == 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_job   = slot_r[rp_r];

  // Advance pointers and occupancy
  always_comb begin
    wp_nxt  = wr_en ? ~wp_r : wp_r;
    rp_nxt  = rd_en ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, wr_en} - {1'b0, rd_en};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Hold the request payload
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_r[wp_r] <= wr_job;
    end
  end

endmodule

// ----- hdl/b32e_back.sv -----
// Back end: walks each request one character per cycle into the output register while it is free or popped.
module b32e_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           job_valid,
  input  b32e_pkg::job_t job,
  output logic           job_done,
  output logic [6:0]     ascii_char,
  output logic           end_of_text,
  output logic           out_empty,
  input  logic           out_pop
);
  import b32e_pkg::*;

  logic [2:0]       idx_r, idx_nxt;
  logic             ov_r, ov_nxt;
  logic [CharW-1:0] ch_r;
  logic             eot_r;

  logic             load;
  logic [3:0]       total;
  logic             last;
  logic [CharW-1:0] ch_c;

  assign out_empty   = ~ov_r;
  assign ascii_char  = ch_r;
  assign end_of_text = eot_r;

  // Pick the character at the current position of the request
  always_comb begin
    load  = job_valid && (!ov_r || out_pop);
    total = {2'b00, job.nsym} + {1'b0, job.npad};
    last  = ({1'b0, idx_r} == (total - 4'd1));
    if (idx_r < {1'b0, job.nsym}) begin
      ch_c = sym_to_char(job.sym[idx_r[1:0]]);
    end else begin
      ch_c = PadChar;
    end
    job_done = load && last;
  end

  // Advance the position and the output valid flag
  always_comb begin
    idx_nxt = idx_r;
    ov_nxt  = ov_r;
    if (load) begin
      idx_nxt = last ? 3'd0 : (idx_r + 3'd1);
      ov_nxt  = 1'b1;
    end else if (out_pop) begin
      ov_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 3'd0;
      ov_r  <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      ov_r  <= ov_nxt;
    end
  end

  // Hold the result payload until popped
  always_ff @(posedge clk) begin
    if (load) begin
      ch_r  <= ch_c;
      eot_r <= last && job.fin;
    end
  end

endmodule

// ----- hdl/base32_stream_encoder.sv -----
// Top level of the streaming Base32 encoder.
//
//  channel | ports                         | handshake
//  --------+-------------------------------+-------------------------------
//  input   | in_data_byte, in_is_final     | accepted on push & !full
//  result  | out_ascii_char, out_end_of_text | accepted on pop & !empty
//
// The front end takes one byte per cycle while the two-entry queue has room.
// The back end emits one character per cycle unless a stalled pop holds the
// output; a byte yields one or two characters and a final byte up to eight,
// so the output character rate sets the byte rate. Reset is synchronous and
// active low; it clears the stream state, the queue and the output register.
// A stalled pop holds the result and backs up the queue, which then raises in_full.
module base32_stream_encoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [7:0] in_data_byte,
  input  logic       in_is_final,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [6:0] out_ascii_char,
  output logic       out_end_of_text
);
  import b32e_pkg::*;

  logic accept;
  job_t fr_job;
  job_t hd_job;
  logic hd_valid;
  logic hd_done;

  assign accept = in_push && !in_full;

  b32e_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .data_byte (in_data_byte),
    .is_final  (in_is_final),
    .job       (fr_job)
  );

  b32e_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (accept),
    .wr_job   (fr_job),
    .full     (in_full),
    .rd_en    (hd_done),
    .rd_valid (hd_valid),
    .rd_job   (hd_job)
  );

  b32e_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .job_valid   (hd_valid),
    .job         (hd_job),
    .job_done    (hd_done),
    .ascii_char  (out_ascii_char),
    .end_of_text (out_end_of_text),
    .out_empty   (out_empty),
    .out_pop     (out_pop)
  );

endmodule
